### rtl/cdve_pkg.sv
package cdve_pkg;

  localparam int POSITION_BITS = 40;
  localparam int WORD_W        = 64;
  localparam int CFG_W         = 17;
  localparam int OFFSET_W      = 48;
  localparam int GROUP_W       = 7;

  localparam logic [CFG_W-1:0] CHUNK_RESET = CFG_W'(1024);
  localparam logic [CFG_W-1:0] CHUNK_MAX   = CFG_W'(65536);
  localparam logic [CFG_W-1:0] CHUNK_MIN   = CFG_W'(1);

  typedef logic [POSITION_BITS-1:0] pos_t;

  // sequencer to shift unit
  typedef struct packed {
    logic load;
    logic calc;
    logic opens;
    logic shift;
    logic commit;
    logic clear;
  } cdve_ctl_t;

  // shift unit to sequencer
  typedef struct packed {
    logic               order_bad;
    logic [GROUP_W-1:0] group;
    logic               more;
  } cdve_sts_t;

endpackage

### rtl/cdve_in_if.sv
interface cdve_in_if;
  import cdve_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] table_word;
  logic              final_entry;

  modport source (output valid, output table_word, output final_entry, input ready);
  modport sink (input valid, input table_word, input final_entry, output ready);
endinterface

interface cdve_out_if;
  import cdve_pkg::*;
  logic                valid;
  logic                ready;
  logic [7:0]          out_byte;
  logic                item_last;
  logic                chunk_start;
  logic [OFFSET_W-1:0] byte_offset;
  logic                stream_end;
  logic                order_error;

  modport source (output valid, output out_byte, output item_last, output chunk_start,
                  output byte_offset, output stream_end, output order_error, input ready);
  modport sink (input valid, input out_byte, input item_last, input chunk_start,
                input byte_offset, input stream_end, input order_error, output ready);
endinterface

interface cdve_cfg_if;
  import cdve_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/chunked_delta_varint_encoder.sv
// Delta encoder with unsigned LEB128 output. Each input beat carries a table word whose low
// POSITION_BITS bits hold an ascending position; the first entry of every chunk of a
// programmable number of entries is sent absolute, later ones as the delta to the previous
// position, as 7-bit groups low first, one output byte per beat. An item of n bytes (1 to 6
// at 40-bit positions) is handled in steps: the beat is taken, the shared subtractor forms the
// delta and checks ordering, then the shift register sends one byte per cycle while the
// consumer does not stall. A position out of order inside a chunk yields one error beat and
// the error stays set until reset. The next item is taken as soon as the last byte sits in
// the output register. The chunk length may be written at any idle time.
module chunked_delta_varint_encoder
  import cdve_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  cdve_in_if.sink    in_ch,
  cdve_out_if.source out_ch,
  cdve_cfg_if.sink   cfg_ch
);

  cdve_ctl_t ctl;
  cdve_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  cdve_shift_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .pos_in (in_ch.table_word[POSITION_BITS-1:0]),
    .ctl    (ctl),
    .sts    (sts)
  );

  cdve_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_final   (in_ch.final_entry),
    .in_ready   (in_ch.ready),
    .cfg_valid  (cfg_ch.valid),
    .cfg_data   (cfg_ch.data),
    .ctl        (ctl),
    .sts        (sts),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .out_last   (out_ch.item_last),
    .out_start  (out_ch.chunk_start),
    .out_offset (out_ch.byte_offset),
    .out_end    (out_ch.stream_end),
    .out_err    (out_ch.order_error)
  );

endmodule

### rtl/cdve_shift_unit.sv
module cdve_shift_unit
  import cdve_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pos_t      pos_in,
  input  cdve_ctl_t ctl,
  output cdve_sts_t sts
);

  pos_t pos_r;
  pos_t prev_r, prev_nxt;
  pos_t value_r, value_nxt;
  logic [POSITION_BITS:0] diff;
  pos_t rest;

  // shared subtractor: delta and order check
  assign diff = {1'b0, pos_r} - {1'b0, prev_r};
  assign rest = value_r >> GROUP_W;

  assign sts.order_bad = diff[POSITION_BITS] | (diff[POSITION_BITS-1:0] == '0);
  assign sts.group     = value_r[GROUP_W-1:0];
  assign sts.more      = (rest != '0);

  always_comb begin
    value_nxt = value_r;
    if (ctl.calc) begin
      value_nxt = ctl.opens ? pos_r : diff[POSITION_BITS-1:0];
    end else if (ctl.shift) begin
      value_nxt = rest;
    end
    prev_nxt = prev_r;
    if (ctl.commit) begin
      prev_nxt = ctl.clear ? '0 : pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pos_r <= pos_in;
    end
    value_r <= value_nxt;
  end

endmodule

### rtl/cdve_seq.sv
module cdve_seq
  import cdve_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_final,
  output logic                in_ready,
  input  logic                cfg_valid,
  input  logic [CFG_W-1:0]    cfg_data,
  output cdve_ctl_t           ctl,
  input  cdve_sts_t           sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                out_start,
  output logic [OFFSET_W-1:0] out_offset,
  output logic                out_end,
  output logic                out_err
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CFG_W-1:0]    chunk_r, chunk_nxt;
  logic [CFG_W-1:0]    fill_r, fill_nxt;
  logic [OFFSET_W-1:0] bytes_r, bytes_nxt;
  logic                err_r, err_nxt;
  logic                final_r, final_nxt;
  logic                opens_r, opens_nxt;
  logic                first_r, first_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [7:0]          byte_r, byte_nxt;
  logic                last_r, last_nxt;
  logic                start_r, start_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic                end_r, end_nxt;
  logic                oerr_r, oerr_nxt;

  logic [CFG_W-1:0]    limit;
  logic [CFG_W-1:0]    fill_eff;
  logic [CFG_W-1:0]    fill_inc;
  logic [OFFSET_W-1:0] bytes_inc;
  logic                slot_free;
  logic                opens;
  logic                tail;

  always_comb begin
    priority if (chunk_r == '0) begin
      limit = CHUNK_MIN;
    end else if (chunk_r > CHUNK_MAX) begin
      limit = CHUNK_MAX;
    end else begin
      limit = chunk_r;
    end
  end

  assign fill_eff  = (fill_r >= limit) ? '0 : fill_r;
  assign fill_inc  = fill_r + CFG_W'(1);
  assign bytes_inc = bytes_r + OFFSET_W'(1);
  assign slot_free = !out_valid_r || out_ready;
  assign opens     = (fill_eff == '0);
  assign tail      = !sts.more && final_r;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;
  assign out_start  = start_r;
  assign out_offset = offset_r;
  assign out_end    = end_r;
  assign out_err    = oerr_r;

  always_comb begin
    state_nxt     = state_r;
    chunk_nxt     = cfg_valid ? cfg_data : chunk_r;
    fill_nxt      = fill_r;
    bytes_nxt     = bytes_r;
    err_nxt       = err_r;
    final_nxt     = final_r;
    opens_nxt     = opens_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_ready;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    start_nxt     = start_r;
    offset_nxt    = offset_r;
    end_nxt       = end_r;
    oerr_nxt      = oerr_r;
    ctl           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          final_nxt = in_final;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        fill_nxt  = fill_eff;
        opens_nxt = opens;
        first_nxt = 1'b1;
        if (err_r || (!opens && sts.order_bad)) begin
          err_nxt   = 1'b1;
          state_nxt = ST_ERR;
        end else begin
          ctl.calc  = 1'b1;
          ctl.opens = opens;
          state_nxt = ST_EMIT;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          byte_nxt      = '0;
          last_nxt      = 1'b1;
          start_nxt     = 1'b0;
          offset_nxt    = bytes_r;
          end_nxt       = 1'b0;
          oerr_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          byte_nxt      = {sts.more, sts.group};
          last_nxt      = !sts.more;
          start_nxt     = opens_r && first_r;
          offset_nxt    = tail ? bytes_inc : bytes_r;
          end_nxt       = tail;
          oerr_nxt      = 1'b0;
          bytes_nxt     = bytes_inc;
          first_nxt     = 1'b0;
          ctl.shift     = 1'b1;
          if (!sts.more) begin
            ctl.commit = 1'b1;
            fill_nxt   = (fill_inc >= limit) ? '0 : fill_inc;
            // stream end starts a fresh stream
            if (final_r) begin
              ctl.clear = 1'b1;
              fill_nxt  = '0;
              bytes_nxt = '0;
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chunk_r     <= CHUNK_RESET;
      fill_r      <= '0;
      bytes_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chunk_r     <= chunk_nxt;
      fill_r      <= fill_nxt;
      bytes_r     <= bytes_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    final_r  <= final_nxt;
    opens_r  <= opens_nxt;
    first_r  <= first_nxt;
    byte_r   <= byte_nxt;
    last_r   <= last_nxt;
    start_r  <= start_nxt;
    offset_r <= offset_nxt;
    end_r    <= end_nxt;
    oerr_r   <= oerr_nxt;
  end

endmodule

### rtl/cdve_checker.sv
module cdve_checker
  import cdve_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [7:0]          out_byte,
  input logic                item_last,
  input logic                stream_end,
  input logic                order_error,
  input logic [OFFSET_W-1:0] byte_offset
);

  // not ready again in the cycle after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken on consecutive cycles");

  a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && order_error) |-> (item_last && !stream_end && out_byte == 8'd0))
    else $error("malformed error beat");

  // continuation bit set exactly when more bytes follow
  a_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte[7] == !item_last || order_error))
    else $error("continuation bit disagrees with item_last");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && stream_end) |-> item_last)
    else $error("stream end before last byte");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(byte_offset)))
    else $error("stalled output beat changed");

endmodule

bind chunked_delta_varint_encoder cdve_checker u_cdve_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .item_last   (out_ch.item_last),
  .stream_end  (out_ch.stream_end),
  .order_error (out_ch.order_error),
  .byte_offset (out_ch.byte_offset)
);
